// ===== design/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler package
// Shared codes, types and defaults for the scheduler table and its cells.
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int TTS_TABLE_DEPTH = 8;
   localparam int TTS_TIME_W      = 16;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_DISPATCH = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_NONE = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_SCAN = 1'b1
   } fsm_type;

   // Broadcast from the controller to every cell in the row.
   typedef struct packed {
      logic                  tick;
      logic                  scan;
      logic [TTS_TIME_W-1:0] timeout;
      logic                  periodic;
   } cmd_type;

   typedef struct packed {
      status_type status;
      logic [2:0] index;
   } rsp_type;

endpackage

// ===== design/tts_cell.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler cell
// One table entry: reload interval, remaining ticks, pending runs, and one
// stage of the dispatch probe that walks down the row.
// ----------------------------------------------------------------------------
module tts_cell
   import tts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    load,
   input  logic    probe_in,
   output logic    pass_out,
   output logic    hit
);

   logic [TTS_TIME_W-1:0] reload_ff,  reload_in;
   logic [TTS_TIME_W-1:0] remain_ff,  remain_in;
   logic [TTS_TIME_W-1:0] pending_ff, pending_in;
   logic                  probe_ff,   probe_in_d;
   logic [TTS_TIME_W-1:0] remain_dec;
   logic                  pending_nz;
   logic                  add_run;

   always_comb begin
      remain_dec = remain_ff - TTS_TIME_W'(1);
      pending_nz = (pending_ff != '0);
      hit        = probe_ff & cmd.scan & pending_nz;
      pass_out   = probe_ff & cmd.scan & ~pending_nz;
      probe_in_d = probe_in;
      reload_in  = reload_ff;
      remain_in  = remain_ff;
      pending_in = pending_ff;
      add_run    = 1'b0;
      if (load) begin
         remain_in  = cmd.timeout;
         reload_in  = cmd.periodic ? cmd.timeout : '0;
         pending_in = '0;
      end else if (cmd.tick) begin
         if (reload_ff != '0) begin
            if (remain_dec == '0) begin
               remain_in = reload_ff;
               add_run   = 1'b1;
            end else begin
               remain_in = remain_dec;
            end
         end else if (remain_ff != '0) begin
            remain_in = remain_dec;
            add_run   = (remain_dec == '0);
         end
         // Pending runs saturate at the top of the range.
         if (add_run && (pending_ff != '1)) begin
            pending_in = pending_ff + TTS_TIME_W'(1);
         end
      end else if (hit) begin
         pending_in = pending_ff - TTS_TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      reload_ff  <= reload_in;
      remain_ff  <= remain_in;
      pending_ff <= pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= 1'b0;
      end else begin
         probe_ff <= probe_in_d;
      end
   end

endmodule

// ===== design/tick_task_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler
// Table of timer task entries held in a row of cells, with tick, add and
// dispatch transactions and a two-entry result queue.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload (lowest bit first)
//   req_*     in         operation[1:0], timeout[17:2], periodic[18], pad
//   rsp_*     out        status[1:0], task_index[4:2], pad
//
// A tick, an add and an unused operation code are handled on acceptance:
// every cell updates its own entry in parallel. A dispatch on an empty
// table is answered with no scan. Any other dispatch starts a scan: the
// probe steps one cell per cycle down the row and stops at the first
// entry with a pending run. Reset clears the entry count, the probe and
// the result queue; entry storage is rewritten on add, so there is no
// clearing pass. A stalled result port holds up to two results before new
// transactions are refused.
module tick_task_scheduler_top
   import tts_pkg::*;
#(
   parameter int TABLE_DEPTH = TTS_TABLE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // operation[1:0], timeout[17:2], periodic[18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // status[1:0], task_index[4:2]
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   function automatic logic [2:0] to_task_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+2:0] wide;
      wide = (IDX_W + 3)'(idx);
      return wide[2:0];
   endfunction

   // Request decode.
   op_type          op;
   logic            accept;
   logic            full;
   logic            start;
   cmd_type         cmd;

   // Controller state.
   fsm_type          state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_ff,  scan_in;
   logic             scan_last;

   // Cell row.
   logic [TABLE_DEPTH-1:0] load;
   logic [TABLE_DEPTH-1:0] probe;
   logic [TABLE_DEPTH-1:0] pass;
   logic [TABLE_DEPTH-1:0] hit;
   logic                   hit_any;

   // Result queue.
   logic    push;
   rsp_type push_data;
   logic    pop;
   rsp_type q_ff [2];
   logic    wr_ptr_ff, rd_ptr_ff;
   logic [1:0] q_cnt_ff;

   assign op     = op_type'(req_tdata[1:0]);
   assign accept = req_tvalid & req_tready;
   assign full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign start  = accept && (op == OP_DISPATCH) && (count_ff != '0);

   assign cmd.tick     = accept && (op == OP_TICK);
   assign cmd.scan     = (state_ff == FSM_SCAN);
   assign cmd.timeout  = req_tdata[17:2];
   assign cmd.periodic = req_tdata[18];

   assign hit_any   = |hit;
   assign scan_last = (CNT_W'(scan_ff) == (count_ff - CNT_W'(1)));

   // The probe enters at cell 0 and moves one cell per cycle while scanning.
   generate
      for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
         assign load[k] = accept && (op == OP_ADD) && !full &&
                          (count_ff == CNT_W'(k));
         if (k == 0) begin : g_head
            assign probe[k] = start;
         end else begin : g_link
            assign probe[k] = pass[k-1];
         end
         tts_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .load     (load[k]),
            .probe_in (probe[k]),
            .pass_out (pass[k]),
            .hit      (hit[k])
         );
      end
   endgenerate

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (hit_any || scan_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Controller outputs: results, entry count and probe position.
   always_comb begin
      push             = 1'b0;
      push_data.status = ST_OK;
      push_data.index  = 3'd0;
      count_in         = count_ff;
      scan_in          = scan_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            scan_in = '0;
            if (accept) begin
               push = 1'b1;
               case (op)
                  OP_ADD: begin
                     if (full) begin
                        push_data.status = ST_FULL;
                     end else begin
                        push_data.index = to_task_index(count_ff[IDX_W-1:0]);
                        count_in        = count_ff + CNT_W'(1);
                     end
                  end
                  OP_DISPATCH: begin
                     // An empty table has nothing to scan.
                     if (count_ff == '0) begin
                        push_data.status = ST_NONE;
                     end else begin
                        push = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         FSM_SCAN: begin
            if (hit_any) begin
               push            = 1'b1;
               push_data.index = to_task_index(scan_ff);
            end else if (scan_last) begin
               push             = 1'b1;
               push_data.status = ST_NONE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   // Two-entry result queue. A transaction is taken only when a slot is free,
   // and only one is in flight, so a push always finds room.
   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign req_tready = (state_ff == FSM_IDLE) && (q_cnt_ff != 2'd2);
   assign rsp_tdata  = {3'b000, q_ff[rd_ptr_ff].index, q_ff[rd_ptr_ff].status};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         q_cnt_ff <= q_cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== design/tts_checker.sv =====
// ----------------------------------------------------------------------------
// Tick task scheduler checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tts_checker
   import tts_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // The result queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Only defined status codes come out.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == ST_OK || rsp_tdata[1:0] == ST_FULL ||
                      rsp_tdata[1:0] == ST_NONE))
      else $error("undefined status code");

   // A failed add or dispatch carries index zero.
   a_fail_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[4:2] == 3'd0))
      else $error("nonzero index on failure");

   // A stalled result is not lost when a transaction is taken.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready
      |=> rsp_tvalid)
      else $error("result lost under backpressure");

endmodule

bind tick_task_scheduler_top tts_checker u_tts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
